FILE: hw/rtl/bracket_stack_checker_core_assert.svh
// Assertion macros for the checker file of the bracket stack checker.
// No dependencies; included by bsc_checker.sv.
`ifndef BRACKET_STACK_CHECKER_CORE_ASSERT_SVH
`define BRACKET_STACK_CHECKER_CORE_ASSERT_SVH

// Implication checked on the same clock edge.
`define BSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked at the next clock edge.
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bsc_pkg.sv
// Package for the bracket stack checker: widths, status codes, register
// indexes, bracket tables and small decode functions. No dependencies.
`timescale 1ns / 1ps

package bsc_pkg;

  localparam int unsigned StackDepthDefault = 128;
  localparam int unsigned SymW    = 8;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CompW   = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned NumKinds = 4;

  typedef enum logic [2:0] {
    ST_BALANCED   = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_CORRUPTED  = 3'd2,
    ST_INVALID    = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  // Register indexes on the configuration channel.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT_PAREN  = 8'd0,
    CFG_WEIGHT_SQUARE = 8'd1,
    CFG_WEIGHT_CURLY  = 8'd2,
    CFG_WEIGHT_ANGLE  = 8'd3
  } cfg_idx_e;

  localparam logic [SymW-1:0] OpenChars [NumKinds] = '{8'h28, 8'h5B, 8'h7B, 8'h3C};
  localparam logic [SymW-1:0] CloseChars [NumKinds] = '{8'h29, 8'h5D, 8'h7D, 8'h3E};
  localparam logic [WeightW-1:0] WeightReset [NumKinds] =
    '{16'd3, 16'd57, 16'd1197, 16'd25137};

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [CodeW-1:0] code;
  } lookup_t;

  function automatic lookup_t find_open(logic [SymW-1:0] sym);
    lookup_t r;
    r = '0;
    for (int i = 0; i < NumKinds; i++) begin
      if (OpenChars[i] == sym) begin
        r.hit  = 1'b1;
        r.code = CodeW'(i);
      end
    end
    return r;
  endfunction

  function automatic lookup_t find_close(logic [SymW-1:0] sym);
    lookup_t r;
    r = '0;
    for (int i = 0; i < NumKinds; i++) begin
      if (CloseChars[i] == sym) begin
        r.hit  = 1'b1;
        r.code = CodeW'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bracket_stack_checker_core.sv
// Top level of the bracket stack checker: line state machine, closer stack
// RAM and result register. Depends on bsc_pkg, bsc_ram and bsc_accum.
//
//   channel   direction  payload
//   s_axis    in         tdata[7:0] symbol, tlast = end of line
//   m_axis    out        tdata: status[2:0], corruption[18:3], completion[82:19]
//   cfg       in         cfg_index_i register index, cfg_data_i weight value
//
// An opener, a non-bracket or an ignored character is handled in S_IDLE alone.
// A matching closer with two or more entries on the stack also passes S_REFILL,
// since the new top of stack is read back through the RAM's registered read port.
// End of line loads the result register directly, but an incomplete line first
// passes S_WALK, which reads the stack one entry a cycle from the top, and S_FINISH.
// Reset clears control state at once; the stack RAM needs no clearing pass.
// Input stalls while a result waits and the output side holds it.
`timescale 1ns / 1ps

module bracket_stack_checker_core import bsc_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // symbol[7:0]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [87:0]          m_axis_tdata,   // line_status[2:0], corruption_score[18:3],
                                               // completion_score[82:19]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [WeightW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DepthW = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REFILL,
    S_WALK,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  status_e             cond_q, cond_d;
  logic [WeightW-1:0]  held_q, held_d;
  logic [CodeW-1:0]    top_q, top_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [WeightW-1:0]  out_corr_q, out_corr_d;
  logic [CompW-1:0]    out_comp_q, out_comp_d;
  logic [WeightW-1:0]  weight_q [NumKinds];

  logic                in_acc;
  logic                load_out;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [CodeW-1:0]    wr_data;
  logic [AddrW-1:0]    rd_addr;
  logic [CodeW-1:0]    rd_data;
  acc_ctrl_t           acc_ctrl;
  logic [CompW-1:0]    acc;
  lookup_t             op_lu, cl_lu;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op_lu         = find_open(s_axis_tdata);
  assign cl_lu         = find_close(s_axis_tdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKinds; i++) begin
        weight_q[i] <= WeightReset[i];
      end
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i <= CFG_WEIGHT_ANGLE)) begin
      weight_q[cfg_index_i[CodeW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    cond_d       = cond_q;
    held_d       = held_q;
    top_d        = top_q;
    idx_d        = idx_q;
    wr_en        = 1'b0;
    wr_addr      = AddrW'(depth_q);
    wr_data      = op_lu.code;
    rd_addr      = '0;
    acc_ctrl     = '0;
    load_out     = 1'b0;
    out_status_d = out_status_q;
    out_corr_d   = out_corr_q;
    out_comp_d   = out_comp_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tlast) begin
          depth_d       = '0;
          cond_d        = ST_BALANCED;
          held_d        = '0;
          acc_ctrl.clear = 1'b1;
          if (cond_q != ST_BALANCED) begin
            load_out     = 1'b1;
            out_status_d = cond_q;
            out_corr_d   = (cond_q == ST_CORRUPTED) ? held_q : '0;
            out_comp_d   = '0;
          end else if (depth_q == '0) begin
            load_out     = 1'b1;
            out_status_d = ST_BALANCED;
            out_corr_d   = '0;
            out_comp_d   = '0;
          end else begin
            rd_addr = AddrW'(depth_q - DepthW'(1));
            idx_d   = AddrW'(depth_q - DepthW'(1));
            state_d = S_WALK;
          end
        end else if (in_acc && (cond_q == ST_BALANCED)) begin
          if (op_lu.hit) begin
            if (depth_q >= DepthW'(StackDepth)) begin
              cond_d = ST_OVERFLOW;
            end else begin
              wr_en   = 1'b1;
              depth_d = depth_q + DepthW'(1);
              top_d   = op_lu.code;
            end
          end else if (cl_lu.hit) begin
            if ((depth_q == '0) || (top_q != cl_lu.code)) begin
              cond_d = ST_CORRUPTED;
              held_d = weight_q[cl_lu.code];
            end else begin
              depth_d = depth_q - DepthW'(1);
              // The entry below the popped one becomes the new top.
              if (depth_q > DepthW'(1)) begin
                rd_addr = AddrW'(depth_q - DepthW'(2));
                state_d = S_REFILL;
              end
            end
          end else begin
            cond_d = ST_INVALID;
          end
        end
      end
      S_REFILL: begin
        top_d   = rd_data;
        state_d = S_IDLE;
      end
      S_WALK: begin
        acc_ctrl.step = 1'b1;
        if (idx_q == '0) begin
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q - AddrW'(1);
          rd_addr = idx_q - AddrW'(1);
        end
      end
      S_FINISH: begin
        load_out     = 1'b1;
        out_status_d = ST_INCOMPLETE;
        out_corr_d   = '0;
        out_comp_d   = acc;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = load_out || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      depth_q      <= '0;
      cond_q       <= ST_BALANCED;
      held_q       <= '0;
      top_q        <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_BALANCED;
      out_corr_q   <= '0;
      out_comp_q   <= '0;
    end else begin
      state_q      <= state_d;
      depth_q      <= depth_d;
      cond_q       <= cond_d;
      held_q       <= held_d;
      top_q        <= top_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_corr_q   <= out_corr_d;
      out_comp_q   <= out_comp_d;
    end
  end

  bsc_ram #(
    .Width (CodeW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bsc_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .code_i (rd_data),
    .acc_o  (acc)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_comp_q, out_corr_q, out_status_q};

endmodule

FILE: hw/rtl/bsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bsc_accum.sv
// Base-five completion score accumulator, one closer code per step.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_accum import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acc_ctrl_t        ctrl_i,
  input  logic [CodeW-1:0] code_i,
  output logic [CompW-1:0] acc_o
);

  logic [CompW-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      // acc * 5 + code + 1, wrapping at the register width.
      acc_d = (acc_q << 2) + acc_q + CompW'(code_i) + CompW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/bsc_checker.sv
// Port-level checks for bracket_stack_checker_core, attached with bind.
// Depends on bsc_pkg and bracket_stack_checker_core_assert.svh.
`timescale 1ns / 1ps
`include "bracket_stack_checker_core_assert.svh"

module bsc_checker import bsc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  logic [2:0]         status;
  logic [WeightW-1:0] corr;
  logic [CompW-1:0]   comp;

  assign status = m_axis_tdata[2:0];
  assign corr   = m_axis_tdata[18:3];
  assign comp   = m_axis_tdata[82:19];

  // A word that is only shown must stay until it is taken.
  `BSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Only a corrupted line carries a corruption score.
  `BSC_ASSERT_IMPL(a_corr_zero, clk_i, rst_ni, m_axis_tvalid && (status != ST_CORRUPTED), corr == '0)

  // Only an incomplete line carries a completion score.
  `BSC_ASSERT_IMPL(a_comp_zero, clk_i, rst_ni, m_axis_tvalid && (status != ST_INCOMPLETE), comp == '0)

  // No new word is taken while a waiting result is held back.
  `BSC_ASSERT_IMPL(a_no_take_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind bracket_stack_checker_core bsc_checker u_bsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/bracket_stack_checker_core_tb.sv
// Self-checking testbench for bracket_stack_checker_core: feeds lines of bracket
// characters, predicts each end-of-line result and checks it word by word.
// Depends on bsc_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module bracket_stack_checker_core_tb;
  import bsc_pkg::*;

  localparam int unsigned StackDepth    = StackDepthDefault;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomWords   = 400;

  localparam cfg_idx_e WeightIdx [NumKinds] =
    '{CFG_WEIGHT_PAREN, CFG_WEIGHT_SQUARE, CFG_WEIGHT_CURLY, CFG_WEIGHT_ANGLE};

  typedef struct packed {
    status_e             status;
    logic [WeightW-1:0]  corruption;
    logic [CompW-1:0]    completion;
  } line_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // symbol[7:0]
  logic                 s_axis_tlast;   // end of line
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [87:0]          m_axis_tdata;   // line_status[2:0], corruption_score[18:3],
                                        // completion_score[82:19]
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [WeightW-1:0]   cfg_data_i;

  bracket_stack_checker_core #(
    .StackDepth(StackDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the line state and the weight registers.
  logic [CodeW-1:0]   closer_stack [StackDepth];
  int unsigned        stack_fill;
  status_e            line_state;   // ST_BALANCED here means the line is still fine
  logic [WeightW-1:0] held_weight;
  logic [WeightW-1:0] weight_reg [NumKinds];

  line_result_t line_results_q [$];
  bit           gaps_on;
  int unsigned  fail_count;
  int unsigned  words_sent;
  int unsigned  lines_sent;
  int unsigned  results_seen;

  function automatic bit take_gap();
    return gaps_on && ($urandom_range(0, 99) < 24);
  endfunction

  function automatic void track_symbol(logic [7:0] sym);
    int opener;
    int closer;
    opener = -1;
    closer = -1;
    for (int i = 0; i < NumKinds; i++) begin
      if (sym == OpenChars[i]) opener = i;
      if (sym == CloseChars[i]) closer = i;
    end
    if (line_state != ST_BALANCED) return;
    if (opener >= 0) begin
      if (stack_fill >= StackDepth) begin
        line_state = ST_OVERFLOW;
      end else begin
        closer_stack[stack_fill] = CodeW'(opener);
        stack_fill++;
      end
    end else if (closer >= 0) begin
      if (stack_fill == 0 || closer_stack[stack_fill-1] != CodeW'(closer)) begin
        line_state  = ST_CORRUPTED;
        held_weight = weight_reg[closer];
      end else begin
        stack_fill--;
      end
    end else begin
      line_state = ST_INVALID;
    end
  endfunction

  function automatic line_result_t close_line();
    line_result_t r;
    r = '0;
    if (line_state != ST_BALANCED) begin
      r.status = line_state;
      if (line_state == ST_CORRUPTED) r.corruption = held_weight;
    end else if (stack_fill != 0) begin
      // Completion score walks the stack from the top, in base five.
      r.status = ST_INCOMPLETE;
      for (int d = int'(stack_fill) - 1; d >= 0; d--) begin
        r.completion = r.completion * 5 + closer_stack[d] + 1;
      end
    end else begin
      r.status = ST_BALANCED;
    end
    stack_fill  = 0;
    line_state  = ST_BALANCED;
    held_weight = '0;
    return r;
  endfunction

  // Returns at the next falling edge with s_axis_tvalid still high; a later gap or settle_idle lowers it.
  task automatic send_word(input bit eol, input logic [7:0] sym);
    while (take_gap()) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sym;
    s_axis_tlast  = eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (eol) begin
      line_results_q = {line_results_q, close_line()};
      lines_sent++;
    end else begin
      track_symbol(sym);
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string txt, input logic [7:0] eol_sym);
    for (int i = 0; i < txt.len(); i++) send_word(1'b0, txt[i]);
    send_word(1'b1, eol_sym);
  endtask

  // Lets every pending line finish before the weights are touched.
  task automatic settle_idle();
    s_axis_tvalid = 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (StackDepth + 8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_weights(input logic [WeightW-1:0] w [NumKinds]);
    logic [CfgIdxW-1:0] idx;
    logic [WeightW-1:0] val;
    for (int i = 0; i <= NumKinds; i++) begin
      // The extra write goes to an unmapped index and must change nothing.
      idx = (i < NumKinds) ? WeightIdx[i] : CfgIdxW'($urandom_range(NumKinds, 255));
      val = (i < NumKinds) ? w[i] : WeightW'($urandom);
      cfg_valid_i = 1'b1;
      cfg_index_i = idx;
      cfg_data_i  = val;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idx < NumKinds) weight_reg[idx] = val;
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  task automatic corrupt_each_kind();
    send_text(")", 8'h00);
    send_text("(]}", 8'hFF);
    send_text("[(}", 8'h5A);
    send_text("{<>(>", 8'hA5);
  endtask

  task automatic send_openers(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(1'b0, OpenChars[$urandom_range(0, NumKinds-1)]);
    end
  endtask

  task automatic random_line(input bit deep, input bit noisy);
    int unsigned      len;
    int unsigned      r;
    int unsigned      code;
    logic [CodeW-1:0] shadow [$];
    logic [7:0]       sym;
    len = deep ? $urandom_range(100, 170) : $urandom_range(0, 24);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (noisy && r < 6) begin
        sym = 8'($urandom_range(0, 255));
      end else if (noisy && r < 12) begin
        sym = CloseChars[$urandom_range(0, NumKinds-1)];
      end else if (shadow.size() != 0 && r >= (deep ? 85 : 55)) begin
        sym = CloseChars[shadow[$]];
        shadow.delete(shadow.size() - 1);
      end else begin
        code = $urandom_range(0, NumKinds-1);
        shadow = {shadow, CodeW'(code)};
        sym = OpenChars[code];
      end
      send_word(1'b0, sym);
    end
    if (!deep && $urandom_range(0, 1)) begin
      while (shadow.size() != 0) begin
        sym = CloseChars[shadow[$]];
        shadow.delete(shadow.size() - 1);
        send_word(1'b0, sym);
      end
    end
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) begin
      random_line($urandom_range(0, 24) == 0, $urandom_range(0, 99) < 40);
    end
    settle_idle();
  endtask

  task automatic test_reset_weights();
    send_word(1'b1, 8'h00);
    send_text("([{<>}])", 8'h28);
    send_text("<{[(", 8'hC3);
    corrupt_each_kind();
    send_text("(a", 8'h3C);
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'h29);
    settle_idle();
  endtask

  task automatic test_weight_extremes();
    logic [WeightW-1:0] w [NumKinds];
    w = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    program_weights(w);
    corrupt_each_kind();
    settle_idle();
    w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    program_weights(w);
    corrupt_each_kind();
    settle_idle();
  endtask

  task automatic test_stack_limits();
    logic [CodeW-1:0] codes [$];
    int unsigned      code;
    logic [7:0]       sym;
    // A full stack left open: the completion score wraps many times over.
    send_openers(StackDepth);
    send_word(1'b1, 8'hFF);
    // One opener too many overflows the stack.
    send_openers(StackDepth + 1);
    send_word(1'b1, 8'h00);
    // Fill the stack and close it again.
    for (int unsigned i = 0; i < StackDepth; i++) begin
      code = $urandom_range(0, NumKinds-1);
      codes = {codes, CodeW'(code)};
      send_word(1'b0, OpenChars[code]);
    end
    while (codes.size() != 0) begin
      sym = CloseChars[codes[$]];
      codes.delete(codes.size() - 1);
      send_word(1'b0, sym);
    end
    send_word(1'b1, 8'h7D);
    settle_idle();
  endtask

  task automatic test_random_lines();
    logic [WeightW-1:0] w [NumKinds];
    for (int i = 0; i < NumKinds; i++) w[i] = WeightW'($urandom_range(0, 65535));
    program_weights(w);
    random_phase(RandomWords / 3);
    // A long stretch with both sides running flat out.
    gaps_on = 1'b0;
    w = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    program_weights(w);
    random_phase(RandomWords / 3);
    gaps_on = 1'b1;
    w = '{16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF};
    program_weights(w);
    random_phase(RandomWords - 2 * (RandomWords / 3));
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = !take_gap();
  end

  always @(posedge clk_i) begin : check_results
    line_result_t want;
    logic [2:0]   got_status;
    logic [15:0]  got_corruption;
    logic [63:0]  got_completion;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status     = m_axis_tdata[2:0];
      got_corruption = m_axis_tdata[18:3];
      got_completion = m_axis_tdata[82:19];
      results_seen++;
      if (line_results_q.size() == 0) begin
        $error("result word with no line pending: status %0d", got_status);
        fail_count++;
      end else begin
        want = line_results_q.pop_front();
        if (got_status != want.status) begin
          $error("line_status: expected %0d, actual %0d", want.status, got_status);
          fail_count++;
        end
        if (got_corruption != want.corruption) begin
          $error("corruption_score: expected %0d, actual %0d", want.corruption,
                 got_corruption);
          fail_count++;
        end
        if (got_completion != want.completion) begin
          $error("completion_score: expected %0d, actual %0d", want.completion,
                 got_completion);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    fail_count    = 0;
    words_sent    = 0;
    lines_sent    = 0;
    results_seen  = 0;
    stack_fill    = 0;
    line_state    = ST_BALANCED;
    held_weight   = '0;
    for (int i = 0; i < NumKinds; i++) weight_reg[i] = WeightReset[i];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_weights();
    test_weight_extremes();
    test_stack_limits();
    test_random_lines();

    $display("Sent %0d words in %0d lines and checked %0d results.", words_sent,
             lines_sent, results_seen);
    $display("Weights ran at reset, zero, full scale and random values.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_ram.sv
hw/rtl/bsc_accum.sv
hw/rtl/bracket_stack_checker_core.sv
hw/rtl/bsc_checker.sv
tb/bracket_stack_checker_core_tb.sv
